// ===== src/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// no dependencies; bodies drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_RST(label, clk, rst_n, prop, msg)

`define ASSERT_CLK(label, clk, prop, msg)

`endif

`endif

// ===== src/scau_pkg.sv =====
// shared types and constants of the stochastic cyclic automaton update block
// no dependencies
`default_nettype none

package scau_pkg;

    localparam int GRID_SIDE_DEF = 64;

    localparam int COORD_W   = 6;
    localparam int COORD_N   = 1 << COORD_W;
    localparam int STATE_W   = 4;
    localparam int UNIF_W    = 11;
    localparam int DIR_W     = 3;
    localparam int RATE_W    = 12;
    localparam int CNT_W     = 4;
    localparam int FUNC_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 60;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_RATES_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATES_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STATES     = 3'd5;

    localparam logic [STATE_W-1:0] STATE_MAX   = 4'd9;
    localparam logic [STATE_W-1:0] STATES_MIN  = 4'd4;
    localparam logic [STATE_W-1:0] STATES_MAX  = 4'd10;
    localparam logic [CNT_W-1:0]   SPAN_MAX    = 4'd8;
    localparam logic [CNT_W-1:0]   THR_RESET   = 4'd1;
    localparam logic [CNT_W-1:0]   SPAN_RESET  = 4'd4;

    typedef enum logic [1:0] {
        OFF_NONE = 2'd0,
        OFF_DEC  = 2'd1,
        OFF_INC  = 2'd2
    } t_off;

    // neighbour order n, s, w, e, nw, ne, sw, se
    localparam t_off NB_DROW [8] = '{OFF_DEC, OFF_INC, OFF_NONE, OFF_NONE,
                                     OFF_DEC, OFF_DEC, OFF_INC, OFF_INC};
    localparam t_off NB_DCOL [8] = '{OFF_NONE, OFF_NONE, OFF_DEC, OFF_INC,
                                     OFF_DEC, OFF_INC, OFF_DEC, OFF_INC};

    typedef struct packed {
        logic load;
        logic rd_centre;
        logic eval;
        logic rd_nb;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic need_nb;
        logic nb_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== src/scau_ctrl.sv =====
// sequencer of the automaton update: one item at a time, at most one grid access a cycle
// depends on scau_pkg
`default_nettype none

module scau_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire                i_out_ready,
    output logic               o_out_valid,
    input  scau_pkg::t_dp_stat i_stat,
    output scau_pkg::t_dp_cmd  o_cmd
);
    import scau_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CENTRE = 6'b000010,
        S_EVAL   = 6'b000100,
        S_NREAD  = 6'b001000,
        S_NLAST  = 6'b010000,
        S_FIN    = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.load    = (r_state == S_IDLE) && i_in_valid;
        n_out_valid   = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CENTRE;
            end
            S_CENTRE: begin
                o_cmd.rd_centre = 1'b1;
                n_state         = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.need_nb ? S_NREAD : S_FIN;
            end
            S_NREAD: begin
                o_cmd.rd_nb = 1'b1;
                if (i_stat.nb_last) n_state = S_NLAST;
            end
            S_NLAST: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.fin   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== src/scau_dp.sv =====
// datapath of the automaton update: config registers, cell grid memory,
// neighbour address generation, match counter and result register; depends on scau_pkg
`default_nettype none

module scau_dp #(
    parameter int GRID_SIDE = scau_pkg::GRID_SIDE_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_wen,
    input  wire  [scau_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [scau_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire  [scau_pkg::FUNC_W-1:0]        i_func,
    input  wire  [scau_pkg::IN_DATA_W-1:0]     i_data,
    input  scau_pkg::t_dp_cmd                  i_cmd,
    output scau_pkg::t_dp_stat                 o_stat,
    output logic [scau_pkg::OUT_DATA_W-1:0]    o_data
);
    import scau_pkg::*;

    localparam int IDX_W = $clog2(GRID_SIDE);
    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(GRID_SIDE - 1);

    function automatic logic [COORD_N-1:0][IDX_W-1:0] mod_tbl();
        logic [COORD_N-1:0][IDX_W-1:0] t;
        for (int i = 0; i < COORD_N; i++) t[i] = IDX_W'(i % GRID_SIDE);
        return t;
    endfunction

    localparam logic [COORD_N-1:0][IDX_W-1:0] COORD_MOD = mod_tbl();

    function automatic logic [IDX_W-1:0] wrap_step(input logic [IDX_W-1:0] v, input t_off o);
        logic [IDX_W-1:0] res;
        unique case (o)
            OFF_DEC:  res = (v == '0) ? IDX_LAST : v - 1'b1;
            OFF_INC:  res = (v == IDX_LAST) ? '0 : v + 1'b1;
            default:  res = v;
        endcase
        return res;
    endfunction

    // config
    logic [CFG_DATA_W-1:0] r_rates_lo, r_rates_hi;
    logic                  r_mode;
    logic [CNT_W-1:0]      r_thr, r_span_raw;
    logic [STATE_W-1:0]    r_states_raw;

    // item
    logic [FUNC_W-1:0]  r_func;
    logic [IDX_W-1:0]   r_row, r_col;
    logic [UNIF_W-1:0]  r_u;
    logic [DIR_W-1:0]   r_dir;
    logic [STATE_W-1:0] r_wv;

    // evaluation
    logic [STATE_W-1:0] r_cur, r_next;
    logic               r_active, r_odd, r_rate_ok;
    logic [DIR_W-1:0]   r_k;
    logic               r_acc_v;
    logic [CNT_W-1:0]   r_cnt;

    logic [STATE_W-1:0] mem [DEPTH];
    logic [STATE_W-1:0] r_rdata;

    logic [STATE_W-1:0] r_out_state;
    logic               r_out_changed;
    logic [CNT_W-1:0]   r_out_match;

    logic [CNT_W-1:0]   span;
    logic [STATE_W-1:0] sc;
    logic [STATE_W-1:0] nx_raw, nx_m1, nx_odd, nx;
    logic [RATE_W-1:0]  rate;
    logic               rd_valid_cell, rd_odd, rd_update;
    logic               dir_ok;
    logic [IDX_W-1:0]   nb_row, nb_col;
    logic [AW-1:0]      centre_addr, nb_addr, raddr;
    logic               fire, we;
    logic [STATE_W-1:0] wdata;

    assign span = (r_span_raw == '0) ? CNT_W'(1) :
                  (r_span_raw > SPAN_MAX) ? SPAN_MAX : r_span_raw;
    assign sc   = (r_states_raw < STATES_MIN) ? STATES_MIN :
                  (r_states_raw > STATES_MAX) ? STATES_MAX : r_states_raw;

    // successor of the centre cell; the odd wrap needs at most two subtractions
    assign nx_raw = r_rdata + 1'b1;
    assign nx_m1  = (nx_raw >= sc) ? nx_raw - sc : nx_raw;
    assign nx_odd = (nx_m1 >= sc) ? nx_m1 - sc : nx_m1;
    assign nx     = r_rdata[0] ? nx_odd : nx_raw;

    always_comb begin
        unique case (r_rdata)
            4'd0:    rate = r_rates_lo[0*RATE_W +: RATE_W];
            4'd1:    rate = r_rates_lo[1*RATE_W +: RATE_W];
            4'd2:    rate = r_rates_lo[2*RATE_W +: RATE_W];
            4'd3:    rate = r_rates_lo[3*RATE_W +: RATE_W];
            4'd4:    rate = r_rates_lo[4*RATE_W +: RATE_W];
            4'd5:    rate = r_rates_hi[0*RATE_W +: RATE_W];
            4'd6:    rate = r_rates_hi[1*RATE_W +: RATE_W];
            4'd7:    rate = r_rates_hi[2*RATE_W +: RATE_W];
            4'd8:    rate = r_rates_hi[3*RATE_W +: RATE_W];
            4'd9:    rate = r_rates_hi[4*RATE_W +: RATE_W];
            default: rate = '0;
        endcase
    end

    assign rd_update     = (r_func == FUNC_UPDATE);
    assign rd_valid_cell = (r_rdata <= STATE_MAX);
    assign rd_odd        = r_rdata[0];
    assign dir_ok        = ({1'b0, r_dir} < span);

    assign o_stat = '{
        need_nb: rd_update && rd_valid_cell && rd_odd && (r_mode || dir_ok),
        nb_last: !r_mode || ({1'b0, r_k} == span - 1'b1)
    };

    assign nb_row      = wrap_step(r_row, NB_DROW[r_k]);
    assign nb_col      = wrap_step(r_col, NB_DCOL[r_k]);
    assign centre_addr = AW'(r_row) * AW'(GRID_SIDE) + AW'(r_col);
    assign nb_addr     = AW'(nb_row) * AW'(GRID_SIDE) + AW'(nb_col);
    assign raddr       = i_cmd.rd_nb ? nb_addr : centre_addr;

    assign fire = r_active && r_rate_ok &&
                  (!r_odd || (r_mode ? (r_cnt >= r_thr) : (r_cnt != '0)));
    assign we    = (r_func == FUNC_WRITE) || fire;
    assign wdata = (r_func == FUNC_WRITE) ? r_wv : r_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rates_lo   <= '0;
            r_rates_hi   <= '0;
            r_mode       <= 1'b0;
            r_thr        <= THR_RESET;
            r_span_raw   <= SPAN_RESET;
            r_states_raw <= STATES_MAX;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                CFG_RATES_LOW:  r_rates_lo   <= i_cfg_wdata;
                CFG_RATES_HIGH: r_rates_hi   <= i_cfg_wdata;
                CFG_MODE:       r_mode       <= i_cfg_wdata[0];
                CFG_THRESHOLD:  r_thr        <= i_cfg_wdata[CNT_W-1:0];
                CFG_SPAN:       r_span_raw   <= i_cfg_wdata[CNT_W-1:0];
                CFG_STATES:     r_states_raw <= i_cfg_wdata[STATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_v <= 1'b0;
        end else begin
            r_acc_v <= i_cmd.rd_nb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_row  <= COORD_MOD[i_data[0 +: COORD_W]];
            r_col  <= COORD_MOD[i_data[COORD_W +: COORD_W]];
            r_u    <= i_data[2*COORD_W +: UNIF_W];
            r_dir  <= i_data[2*COORD_W+UNIF_W +: DIR_W];
            r_wv   <= i_data[2*COORD_W+UNIF_W+DIR_W +: STATE_W];
        end
        if (i_cmd.eval) begin
            r_cur     <= (r_func == FUNC_WRITE) ? r_wv : r_rdata;
            r_next    <= nx;
            r_active  <= rd_update && rd_valid_cell;
            r_odd     <= rd_odd;
            r_rate_ok <= ({1'b0, r_u} < rate);
            r_k       <= r_mode ? '0 : r_dir;
            r_cnt     <= '0;
        end else begin
            if (i_cmd.rd_nb) r_k <= r_k + 1'b1;
            if (r_acc_v && (r_rdata == r_next)) r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.fin) begin
            r_out_state   <= fire ? r_next : r_cur;
            r_out_changed <= fire;
            r_out_match   <= (r_active && r_odd && r_mode) ? r_cnt : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_centre || i_cmd.rd_nb) r_rdata <= mem[raddr];
        if (i_cmd.fin && we) mem[centre_addr] <= wdata;
    end

    assign o_data = {{(OUT_DATA_W-STATE_W-1-CNT_W){1'b0}}, r_out_match, r_out_changed,
                     r_out_state};

endmodule

`default_nettype wire

// ===== src/stochastic_cyclic_automaton_update.sv =====
// one item at a time; a write or read, or an update that needs no neighbour, steps through
// the centre read, evaluate and finish states, and the result is registered for output
// an update of an odd valid state reads its neighbours one a cycle from the single grid
// memory port: one in direct mode when the direction is within the span, the span in threshold mode
// synchronous active-low reset clears control and config; the grid is not cleared
// depends on scau_pkg, scau_ctrl, scau_dp, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module stochastic_cyclic_automaton_update #(
    parameter int GRID_SIDE = scau_pkg::GRID_SIDE_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wen,
    input  wire  [scau_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [scau_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // row, col, uniform, direction, write_value, zero fill
    input  wire  [scau_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // func
    input  wire  [scau_pkg::FUNC_W-1:0]         s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // cell_state, changed, match_count, zero fill
    output logic [scau_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import scau_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    scau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    scau_dp #(
        .GRID_SIDE (GRID_SIDE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_func      (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_data      (m_axis_tdata)
    );

    `ASSERT_RST(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while an item is in work")
    `ASSERT_RST(a_fin_valid, i_clk, i_rst_n, cmd.fin |=> m_axis_tvalid, "finished item not shown on output")
    `ASSERT_RST(a_changed_state, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[STATE_W] |-> m_axis_tdata[STATE_W-1:0] <= STATE_MAX, "changed cell holds a state above nine")

endmodule

`default_nettype wire

// ===== dv/tb_stochastic_cyclic_automaton_update.sv =====
// testbench for stochastic_cyclic_automaton_update: writes, reads and updates on a toroidal grid,
// each result checked against a cycle-free predictor of the cell grid and its settings
// depends on scau_pkg and the rtl of stochastic_cyclic_automaton_update
`timescale 1ns / 1ps

module tb_stochastic_cyclic_automaton_update;
    import scau_pkg::*;

    localparam int SIDE = GRID_SIDE_DEF;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd3;
    localparam int ROW_STEP [8] = '{-1, 1, 0, 0, -1, -1, 1, 1};
    localparam int COL_STEP [8] = '{0, 0, -1, 1, -1, 1, -1, 1};

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [STATE_W-1:0] write_value;
        logic [DIR_W-1:0]   direction;
        logic [UNIF_W-1:0]  uniform;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } t_cell_cmd;

    typedef struct packed {
        logic [CNT_W-1:0]   match_count;
        logic               changed;
        logic [STATE_W-1:0] cell_state;
    } t_cell_out;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    // row, col, uniform, direction, write_value, zero fill
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    // func
    logic [FUNC_W-1:0]      s_axis_tuser = '0;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // cell_state, changed, match_count, zero fill
    wire  [OUT_DATA_W-1:0]  m_axis_tdata;

    stochastic_cyclic_automaton_update dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // predictor copy of the grid and the settings
    logic [STATE_W-1:0] grid_image [SIDE*SIDE];
    bit                 seeded [SIDE*SIDE];
    logic [59:0]        rate_lo = '0;
    logic [59:0]        rate_hi = '0;
    logic               thr_mode = 1'b0;
    logic [3:0]         thr_min = THR_RESET;
    logic [3:0]         nb_span = SPAN_RESET;
    logic [3:0]         n_states = STATES_MAX;

    t_cell_cmd cmd_pending [$];
    t_cell_out expected_cells [$];
    t_cell_cmd cmd_on_bus;
    int beats_made = 0;
    int beats_taken = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    function automatic int live_states();
        if (n_states < STATES_MIN) return STATES_MIN;
        if (n_states > STATES_MAX) return STATES_MAX;
        return n_states;
    endfunction

    function automatic int unsigned state_rate(int unsigned st);
        logic [59:0] bank;
        bank = (st < 5) ? rate_lo : rate_hi;
        return 32'((bank >> (RATE_W * (st % 5))) & 60'hFFF);
    endfunction

    function automatic logic [STATE_W-1:0] nb_state(int r, int c, int d);
        int rr;
        int cc;
        rr = (r + SIDE + ROW_STEP[d]) % SIDE;
        cc = (c + SIDE + COL_STEP[d]) % SIDE;
        return grid_image[rr * SIDE + cc];
    endfunction

    function automatic t_cell_out evolve_cell(t_cell_cmd cmd);
        t_cell_out res;
        int pos;
        int cur;
        int nxt;
        int span;
        int hits;
        bit fire;
        pos = cmd.row * SIDE + cmd.col;
        cur = grid_image[pos];
        hits = 0;
        res = '0;
        if (cmd.func == FUNC_WRITE) begin
            grid_image[pos] = cmd.write_value;
            cur = cmd.write_value;
        end else if (cmd.func == FUNC_UPDATE && cur <= STATE_MAX) begin
            fire = cmd.uniform < state_rate(cur);
            if (cur % 2 == 0) begin
                nxt = cur + 1;
            end else begin
                span = (nb_span == 0) ? 1 : ((nb_span > SPAN_MAX) ? SPAN_MAX : nb_span);
                nxt = (cur + 1) % live_states();
                if (thr_mode) begin
                    for (int i = 0; i < span; i++)
                        if (nb_state(cmd.row, cmd.col, i) == nxt) hits++;
                    fire = fire && hits >= thr_min;
                end else begin
                    fire = fire && cmd.direction < span
                        && nb_state(cmd.row, cmd.col, cmd.direction) == nxt;
                end
            end
            if (fire) begin
                grid_image[pos] = STATE_W'(nxt);
                res.changed = (nxt != cur);
                cur = nxt;
            end
        end
        res.cell_state = STATE_W'(cur);
        res.match_count = CNT_W'(hits);
        return res;
    endfunction

    function automatic void queue_cmd(logic [FUNC_W-1:0] f, int r, int c, int u, int d, int wv);
        t_cell_cmd cmd;
        cmd.func = f;
        cmd.row = COORD_W'(r);
        cmd.col = COORD_W'(c);
        cmd.uniform = UNIF_W'(u);
        cmd.direction = DIR_W'(d);
        cmd.write_value = STATE_W'(wv);
        cmd_pending.push_back(cmd);
        beats_made++;
        if (f == FUNC_WRITE) seeded[r * SIDE + c] = 1'b1;
    endfunction

    function automatic int pick_state();
        case ($urandom_range(19))
            0: return $urandom_range(15, 10);
            1, 2, 3, 4: return $urandom_range(9);
            default: return $urandom_range(live_states() - 1);
        endcase
    endfunction

    function automatic void seed_cell(int r, int c);
        if (!seeded[r * SIDE + c])
            queue_cmd(FUNC_WRITE, r, c, $urandom_range(2047), $urandom_range(7), pick_state());
    endfunction

    // centre and all eight neighbours hold a written state before an update
    function automatic void seed_block(int r, int c);
        seed_cell(r, c);
        for (int d = 0; d < 8; d++)
            seed_cell((r + SIDE + ROW_STEP[d]) % SIDE, (c + SIDE + COL_STEP[d]) % SIDE);
    endfunction

    function automatic logic [59:0] pick_rates();
        logic [59:0] v;
        for (int k = 0; k < 5; k++)
            case ($urandom_range(4))
                0: v[RATE_W*k +: RATE_W] = 12'h000;
                1: v[RATE_W*k +: RATE_W] = 12'h800;
                2: v[RATE_W*k +: RATE_W] = 12'hFFF;
                3: v[RATE_W*k +: RATE_W] = RATE_W'($urandom_range(12'hFFF));
                default: v[RATE_W*k +: RATE_W] = RATE_W'($urandom_range(12'h800, 12'h400));
            endcase
        return v;
    endfunction

    function automatic void queue_random_cmd();
        int r;
        int c;
        int u;
        int roll;
        // mostly a small window across the wrap corner so updates interact
        if ($urandom_range(19) == 0) begin
            r = $urandom_range(SIDE - 1);
            c = $urandom_range(SIDE - 1);
        end else begin
            r = (SIDE - 2 + $urandom_range(5)) % SIDE;
            c = (SIDE - 2 + $urandom_range(5)) % SIDE;
        end
        case ($urandom_range(9))
            0: u = 0;
            1: u = 2047;
            default: u = $urandom_range(2047);
        endcase
        roll = $urandom_range(99);
        if (roll < 20) begin
            queue_cmd(FUNC_WRITE, r, c, u, $urandom_range(7), pick_state());
        end else if (roll < 32) begin
            seed_cell(r, c);
            queue_cmd(roll < 26 ? FUNC_READ : FUNC_PEEK, r, c, u, $urandom_range(7),
                      $urandom_range(15));
        end else begin
            seed_block(r, c);
            queue_cmd(FUNC_UPDATE, r, c, u, $urandom_range(7), $urandom_range(15));
        end
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_RATES_LOW:  rate_lo = val;
            CFG_RATES_HIGH: rate_hi = val;
            CFG_MODE:       thr_mode = val[0];
            CFG_THRESHOLD:  thr_min = val[3:0];
            CFG_SPAN:       nb_span = val[3:0];
            CFG_STATES:     n_states = val[3:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(bit mode, int thr, int span, int states,
                                 logic [59:0] lo, logic [59:0] hi);
        write_reg(CFG_RATES_LOW, lo);
        write_reg(CFG_RATES_HIGH, hi);
        write_reg(CFG_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(CFG_SPAN, CFG_DATA_W'(span));
        write_reg(CFG_STATES, CFG_DATA_W'(states));
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    task automatic settle();
        while (beats_taken != beats_made || expected_cells.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic compare_field(string label, int want, int got);
        if (want != got) begin
            $display("%0t %s expected %0d actual %0d", $time, label, want, got);
            fail_count++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin : feed
        bit offer;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            offer = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                expected_cells.push_back(evolve_cell(cmd_on_bus));
                beats_taken++;
                offer = 1'b0;
            end
            if (!offer && cmd_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cmd_on_bus = cmd_pending.pop_front();
                s_axis_tdata <= {2'b00, cmd_on_bus.write_value, cmd_on_bus.direction,
                                 cmd_on_bus.uniform, cmd_on_bus.col, cmd_on_bus.row};
                s_axis_tuser <= cmd_on_bus.func;
                offer = 1'b1;
            end
            s_axis_tvalid <= offer;
        end
    end

    // monitor
    always @(posedge i_clk) begin : watch
        t_cell_out seen;
        t_cell_out want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen = m_axis_tdata[8:0];
                if (expected_cells.size() == 0) begin
                    $display("%0t result beat with none expected, actual %h", $time, m_axis_tdata);
                    fail_count++;
                end else begin
                    want = expected_cells.pop_front();
                    compare_field("cell_state", want.cell_state, seen.cell_state);
                    compare_field("changed", want.changed, seen.changed);
                    compare_field("match_count", want.match_count, seen.match_count);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_stochastic_cyclic_automaton_update NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // rates: state 1 above always, state 2 at half, state 4 never
        load_settings(0, 1, 4, 10, {12'h000, 12'h800, 12'h400, 12'hFFF, 12'h800},
                      {5{12'h800}});
        queue_cmd(FUNC_WRITE, 0, 0, 0, 0, 1);
        queue_cmd(FUNC_WRITE, 63, 0, 0, 0, 2);
        queue_cmd(FUNC_WRITE, 1, 0, 0, 0, 0);
        queue_cmd(FUNC_WRITE, 0, 63, 0, 0, 5);
        queue_cmd(FUNC_WRITE, 0, 1, 0, 0, 2);
        queue_cmd(FUNC_WRITE, 63, 63, 2047, 7, 2);
        queue_cmd(FUNC_WRITE, 63, 1, 0, 0, 4);
        queue_cmd(FUNC_WRITE, 1, 63, 0, 0, 9);
        queue_cmd(FUNC_WRITE, 1, 1, 0, 0, 2);
        // successor to the north, top of the fraction range
        queue_cmd(FUNC_UPDATE, 0, 0, 2047, 0, 0);
        // even state at its rate edge, then just below
        queue_cmd(FUNC_UPDATE, 0, 0, 1024, 0, 0);
        queue_cmd(FUNC_UPDATE, 0, 0, 1023, 0, 0);
        queue_cmd(FUNC_UPDATE, 0, 0, 0, 1, 0);
        // nine wraps to zero
        queue_cmd(FUNC_WRITE, 0, 0, 0, 0, 9);
        queue_cmd(FUNC_UPDATE, 0, 0, 0, 1, 0);
        // direction past the span
        queue_cmd(FUNC_WRITE, 0, 0, 0, 0, 3);
        queue_cmd(FUNC_UPDATE, 0, 0, 0, 5, 0);
        // state above nine stays put
        queue_cmd(FUNC_WRITE, 0, 0, 0, 0, 12);
        queue_cmd(FUNC_UPDATE, 0, 0, 0, 0, 0);
        queue_cmd(FUNC_PEEK, 0, 0, 2047, 7, 15);
        queue_cmd(FUNC_READ, 0, 63, 0, 0, 0);

        for (int p = 0; p < 9; p++) begin
            settle();
            case (p)
                0: load_settings(0, 1, 4, 10, {5{12'h800}}, {5{12'h800}});
                1: load_settings(1, 1, 8, 10, pick_rates(), pick_rates());
                2: load_settings(1, 0, 0, 3, pick_rates(), pick_rates());
                3: load_settings(1, 9, 15, 15, pick_rates(), pick_rates());
                4: load_settings(0, 1, 8, 4, 60'hFFF_FFFF_FFFF_FFFF, 60'hFFF_FFFF_FFFF_FFFF);
                5: load_settings(1, 8, 8, 0, '0, 60'hFFF_FFFF_FFFF_FFFF);
                6: load_settings(1, 2, 4, 7, pick_rates(), pick_rates());
                7: load_settings(0, 15, 1, 10, pick_rates(), pick_rates());
                default: load_settings(1'($urandom_range(1)), $urandom_range(15),
                                       $urandom_range(15), $urandom_range(15),
                                       pick_rates(), pick_rates());
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            if (p == 2) begin
                repeat (ITEMS_PER_PHASE / 2) queue_random_cmd();
                settle();
                repeat (ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2) queue_random_cmd();
            end else begin
                repeat (ITEMS_PER_PHASE) queue_random_cmd();
            end
        end

        settle();
        if (fail_count == 0 && expected_cells.size() == 0) begin
            $display("tb_stochastic_cyclic_automaton_update OK");
        end else begin
            $display("tb_stochastic_cyclic_automaton_update NOT OK");
        end
        $finish;
    end

endmodule
